// ===== rtl/ath_pkg.sv =====
// ----------------------------------------------------------------------------
// ath_pkg: shared types and constants for the allocation tracker
// Table geometry, slot codes, event kinds and the hash function.
// ----------------------------------------------------------------------------
package ath_pkg;

  localparam int unsigned TableEntries = 16384;
  localparam int unsigned SlotBits     = $clog2(TableEntries);
  localparam int unsigned ProbeMax     = 256;
  localparam int unsigned LimitBits    = 9;
  localparam int unsigned CountBits    = $clog2(ProbeMax + 1);
  localparam int unsigned HashPreShift  = 4;
  localparam int unsigned HashFoldShift = 17;

  localparam logic [31:0] SlotEmpty = 32'd0;
  localparam logic [31:0] SlotTomb  = 32'd1;

  localparam logic [1:0] KindAlloc   = 2'd0;
  localparam logic [1:0] KindFree    = 2'd1;
  localparam logic [1:0] KindRealloc = 2'd2;
  localparam logic [1:0] KindNone    = 2'd3;

  typedef logic [SlotBits-1:0] slot_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [31:0] new_address;
    logic [31:0] byte_count;
  } event_t;

  typedef struct packed {
    logic [63:0] live_bytes;
    logic [63:0] peak_bytes;
    logic [31:0] removed_size;
    logic        inserted;
    logic [63:0] fail_count;
    logic [63:0] untracked_count;
    logic [63:0] requested_bytes;
  } result_t;

  // Table access bundle between sequencer and slot memory.
  typedef struct packed {
    logic        rd_en;
    slot_t       rd_slot;
    logic        wr_en;
    slot_t       wr_slot;
    logic [31:0] wr_address;
    logic [31:0] wr_size;
  } mem_req_t;

  function automatic slot_t home_slot(logic [31:0] a);
    logic [31:0] v;
    v = a >> HashPreShift;
    v = v ^ (v >> HashFoldShift);
    return v[SlotBits-1:0];
  endfunction

endpackage

// ===== rtl/ath_if.sv =====
// ----------------------------------------------------------------------------
// ath_if: valid/ready channel interfaces
// Event, result and configuration channels.
// ----------------------------------------------------------------------------
interface ath_event_if;
  logic            valid;
  logic            ready;
  ath_pkg::event_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ath_result_if;
  logic             valid;
  logic             ready;
  ath_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ath_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ath_pkg::LimitBits-1:0]    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ath_slot_mem.sv =====
// ----------------------------------------------------------------------------
// ath_slot_mem: slot table storage
// One write port, one registered read port, address and size per slot.
// ----------------------------------------------------------------------------
module ath_slot_mem (
  input  logic              clk,
  input  ath_pkg::mem_req_t req,
  output logic [31:0]       rd_address,
  output logic [31:0]       rd_size
);

  logic [63:0] mem [ath_pkg::TableEntries];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_slot] <= {req.wr_address, req.wr_size};
    end
    if (req.rd_en) begin
      {rd_address, rd_size} <= mem[req.rd_slot];
    end
  end

endmodule

// ===== rtl/allocation_tracker_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// allocation_tracker_hash_table_unit: live allocation tracker
// Open-addressed slot table with linear probing and tombstone reuse.
// ----------------------------------------------------------------------------
// Each table pass sets up the home slot, then reads and checks one slot at a
//   time until it ends; a realloc makes up to two passes (remove, then insert).
// Throughput: one event at a time; the next event is taken only after the
//   result is accepted, in the idle state that follows the result state.
// Reset: rst clears totals and sweeps the table to empty, one slot a cycle,
//   through every slot, during which no event is taken. Limit resets to 256.
module allocation_tracker_hash_table_unit (
  input  logic           clk,
  input  logic           rst,
  ath_event_if.sink      events,
  ath_result_if.source   results,
  ath_cfg_if.sink        cfg
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_READ, S_CHECK, S_AFTER_TAKE,
    S_FINISH, S_OUT
  } state_t;

  state_t                         state;
  ath_pkg::event_t                ev;
  ath_pkg::slot_t                 clear_slot;
  ath_pkg::slot_t                 probe_slot;
  ath_pkg::slot_t                 tomb_slot;
  logic                           have_tomb;
  logic [ath_pkg::CountBits-1:0]  probe_idx;
  logic [ath_pkg::CountBits-1:0]  probe_n;
  logic [ath_pkg::LimitBits-1:0]  probe_limit;
  logic                           is_put;       // current pass inserts
  logic                           take_done;    // realloc remove pass done
  logic [31:0]                    key;
  logic [31:0]                    put_size;
  logic [31:0]                    removed;
  logic                           ins;
  logic                           put_ok;
  logic                           put_fail;
  logic [63:0]                    live_total;
  logic [63:0]                    peak_total;
  logic [63:0]                    req_total;
  logic [63:0]                    failures;
  logic [63:0]                    untracked;
  ath_pkg::mem_req_t              mreq;
  logic [31:0]                    rd_address;
  logic [31:0]                    rd_size;

  ath_slot_mem u_mem (
    .clk        (clk),
    .req        (mreq),
    .rd_address (rd_address),
    .rd_size    (rd_size)
  );

  assign events.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;
  assign results.valid = (state == S_OUT);
  assign results.data = '{live_bytes: live_total, peak_bytes: peak_total,
                          removed_size: removed, inserted: ins,
                          fail_count: failures, untracked_count: untracked,
                          requested_bytes: req_total};

  logic [ath_pkg::CountBits-1:0] limit_cut;
  assign limit_cut = (probe_limit > ath_pkg::LimitBits'(ath_pkg::ProbeMax))
                   ? ath_pkg::CountBits'(ath_pkg::ProbeMax)
                   : ath_pkg::CountBits'(probe_limit);

  logic last_probe;
  assign last_probe = (probe_idx + 1'b1 >= probe_n);

  // Memory request: the read address is the current probe slot, writes come
  // from the clearing sweep, the commit of a found slot or a removal's tombstone.
  logic        hit_key, hit_empty, hit_tomb;
  assign hit_key   = (rd_address == key);
  assign hit_empty = (rd_address == ath_pkg::SlotEmpty);
  assign hit_tomb  = (rd_address == ath_pkg::SlotTomb);

  always_comb begin
    mreq = '0;
    mreq.rd_en   = (state == S_READ);
    mreq.rd_slot = probe_slot;
    if (state == S_CLEAR) begin
      mreq.wr_en   = 1'b1;
      mreq.wr_slot = clear_slot;
    end else if (state == S_CHECK) begin
      if (is_put) begin
        if (hit_key) begin
          mreq.wr_en = 1'b1; mreq.wr_slot = probe_slot;
          mreq.wr_address = key; mreq.wr_size = put_size;
        end else if (hit_empty) begin
          mreq.wr_en = 1'b1;
          mreq.wr_slot = have_tomb ? tomb_slot : probe_slot;
          mreq.wr_address = key; mreq.wr_size = put_size;
        end else if (last_probe && (have_tomb || hit_tomb)) begin
          mreq.wr_en = 1'b1;
          mreq.wr_slot = have_tomb ? tomb_slot : probe_slot;
          mreq.wr_address = key; mreq.wr_size = put_size;
        end
      end else if (hit_key) begin
        mreq.wr_en = 1'b1; mreq.wr_slot = probe_slot;
        mreq.wr_address = ath_pkg::SlotTomb;
      end
    end
  end

  // Start a pass; key 0 or 1 and zero limit end it at once.
  logic pass_skip;
  always_comb begin
    pass_skip = (key == ath_pkg::SlotEmpty) || (key == ath_pkg::SlotTomb) ||
                (probe_n == '0);
  end

  logic [63:0] live_dec;
  assign live_dec = (live_total >= {32'd0, rd_size}) ? live_total - {32'd0, rd_size}
                                                     : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clear_slot  <= '0;
      probe_limit <= ath_pkg::LimitBits'(ath_pkg::ProbeMax);
      live_total  <= '0;
      peak_total  <= '0;
      req_total   <= '0;
      failures    <= '0;
      untracked   <= '0;
    end else begin
      if (cfg.valid) begin
        probe_limit <= cfg.data;
      end
      case (state)
        S_CLEAR: begin
          clear_slot <= clear_slot + 1'b1;
          if (clear_slot == ath_pkg::slot_t'(ath_pkg::TableEntries - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (events.valid) begin
            ev        <= events.data;
            removed   <= '0;
            ins       <= 1'b0;
            put_ok    <= 1'b0;
            put_fail  <= 1'b0;
            take_done <= 1'b0;
            probe_n   <= limit_cut;
            state     <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          // Choose the next table pass for this event, or finish.
          state <= S_FINISH;
          have_tomb <= 1'b0;
          probe_idx <= '0;
          if (ev.kind == ath_pkg::KindAlloc) begin
            req_total <= req_total + {32'd0, ev.byte_count};
            if (ev.address == '0) begin
              failures <= failures + 1'b1;
            end else begin
              key <= ev.address; put_size <= ev.byte_count; is_put <= 1'b1;
              state <= S_AFTER_TAKE;
            end
          end else if ((ev.kind inside {ath_pkg::KindFree, ath_pkg::KindRealloc}) &&
                       !take_done) begin
            key <= ev.address; is_put <= 1'b0; take_done <= 1'b1;
            state <= (ev.address == '0) ? S_DISPATCH : S_AFTER_TAKE;
          end else if (ev.kind == ath_pkg::KindRealloc) begin
            // Remove pass done: follow with reinsert or new allocate, if any.
            ev.kind <= ath_pkg::KindNone;
            if (ev.new_address == '0) begin
              failures <= failures + 1'b1;
              if (removed != '0) begin
                key <= ev.address; put_size <= removed; is_put <= 1'b1;
                state <= S_AFTER_TAKE;
              end
            end else begin
              req_total <= req_total + {32'd0, ev.byte_count};
              key <= ev.new_address; put_size <= ev.byte_count; is_put <= 1'b1;
              state <= S_AFTER_TAKE;
            end
          end
        end
        S_AFTER_TAKE: begin
          // Set up the first probe of the pass.
          probe_slot <= ath_pkg::home_slot(key);
          if (pass_skip) begin
            if (is_put) begin
              put_fail <= 1'b1;
            end
            state <= S_FINISH;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          state <= S_READ;
          probe_slot <= probe_slot + 1'b1;
          probe_idx  <= probe_idx + 1'b1;
          if (is_put) begin
            if (hit_key || hit_empty || (last_probe && (have_tomb || hit_tomb))) begin
              put_ok <= 1'b1;
              state  <= S_FINISH;
            end else begin
              if (hit_tomb && !have_tomb) begin
                have_tomb <= 1'b1;
                tomb_slot <= probe_slot;
              end
              if (last_probe) begin
                put_fail <= 1'b1;
                state <= S_FINISH;
              end
            end
          end else begin
            if (hit_key) begin
              removed <= rd_size;
              if (rd_size != '0) begin
                live_total <= live_dec;
              end
              state <= S_FINISH;
            end else if (hit_empty || last_probe) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          // Close a pass: apply insert outcome, then go on or report.
          if (put_ok) begin
            live_total <= live_total + {32'd0, put_size};
            if (live_total + {32'd0, put_size} > peak_total) begin
              peak_total <= live_total + {32'd0, put_size};
            end
            ins <= 1'b1;
          end
          if (put_fail) begin
            untracked <= untracked + 1'b1;
          end
          put_ok   <= 1'b0;
          put_fail <= 1'b0;
          if (!is_put && ev.kind == ath_pkg::KindRealloc) begin
            state <= S_DISPATCH;
          end else begin
            state <= S_OUT;
          end
          is_put <= 1'b0;
        end
        S_OUT: begin
          if (results.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_event: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> !events.ready)
    else $error("event taken while result pending");
  a_no_clear_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !mreq.rd_en)
    else $error("probe during clear sweep");
  a_peak: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (peak_total >= live_total || live_total == '0))
    else $error("peak below live");

endmodule

// ===== sim/tb_allocation_tracker_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// Allocation tracker testbench
// Drives allocate, free and reallocate events through the valid/ready event
// channel under random idling and checks every result field against a
// behavioral table model kept in the scoreboard. Sweeps the probe limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_allocation_tracker_hash_table_unit;
  import ath_pkg::*;

  localparam int unsigned WatchdogLimit = 60000;

  // Scoreboard: tracker model plus queue of predicted results.
  class tracker_scoreboard;
    logic [31:0] tab_addr [TableEntries];
    logic [31:0] tab_size [TableEntries];
    logic [63:0] live, peak, req_total, fails, lost;
    logic [LimitBits-1:0] limit;
    result_t pending [$];
    int errors;

    function void clear();
      for (int i = 0; i < TableEntries; i++) begin
        tab_addr[i] = SlotEmpty;
        tab_size[i] = '0;
      end
      live = '0; peak = '0; req_total = '0; fails = '0; lost = '0;
      limit = 9'd256;
      errors = 0;
    endfunction

    function int unsigned probes();
      return (limit > ProbeMax) ? ProbeMax : limit;
    endfunction

    function slot_t hash(logic [31:0] a);
      logic [31:0] v;
      v = a >> 4;
      v = v ^ (v >> 17);
      return v[SlotBits-1:0];
    endfunction

    function bit put(logic [31:0] a, logic [31:0] sz);
      slot_t s, tomb;
      bit have_tomb;
      have_tomb = 0;
      tomb = '0;
      if (a == SlotEmpty || a == SlotTomb) return 0;
      for (int i = 0; i < probes(); i++) begin
        s = hash(a) + slot_t'(i);
        if (tab_addr[s] == a) begin
          tab_size[s] = sz;
          return 1;
        end
        if (tab_addr[s] == SlotTomb) begin
          if (!have_tomb) begin
            have_tomb = 1;
            tomb = s;
          end
        end else if (tab_addr[s] == SlotEmpty) begin
          if (have_tomb) s = tomb;
          tab_addr[s] = a;
          tab_size[s] = sz;
          return 1;
        end
      end
      if (have_tomb) begin
        tab_addr[tomb] = a;
        tab_size[tomb] = sz;
        return 1;
      end
      return 0;
    endfunction

    function logic [31:0] take(logic [31:0] a);
      slot_t s;
      logic [31:0] old;
      if (a == SlotEmpty || a == SlotTomb) return '0;
      for (int i = 0; i < probes(); i++) begin
        s = hash(a) + slot_t'(i);
        if (tab_addr[s] == SlotEmpty) return '0;
        if (tab_addr[s] == a) begin
          old = tab_size[s];
          tab_addr[s] = SlotTomb;
          tab_size[s] = '0;
          return old;
        end
      end
      return '0;
    endfunction

    function void grow(logic [31:0] sz);
      live = live + 64'(sz);
      if (live > peak) peak = live;
    endfunction

    function bit alloc(logic [31:0] a, logic [31:0] sz);
      req_total = req_total + 64'(sz);
      if (a == 0) begin
        fails++;
        return 0;
      end
      if (put(a, sz)) begin
        grow(sz);
        return 1;
      end
      lost++;
      return 0;
    endfunction

    // Note an accepted event and queue the result it must produce.
    function void note_event(event_t ev);
      result_t r;
      logic [31:0] gone;
      bit ins;
      gone = '0;
      ins = 0;
      if (ev.kind == KindAlloc) begin
        ins = alloc(ev.address, ev.byte_count);
      end else if (ev.kind inside {KindFree, KindRealloc}) begin
        if (ev.address != 0) begin
          gone = take(ev.address);
          if (gone > 0) live = (live >= 64'(gone)) ? live - 64'(gone) : '0;
        end
        if (ev.kind == KindRealloc) begin
          if (ev.new_address == 0) begin
            fails++;
            if (ev.address != 0 && gone > 0) begin
              if (put(ev.address, gone)) begin
                grow(gone);
                ins = 1;
              end else begin
                lost++;
              end
            end
          end else begin
            ins = alloc(ev.new_address, ev.byte_count);
          end
        end
      end
      r.live_bytes = live;
      r.peak_bytes = peak;
      r.removed_size = gone;
      r.inserted = ins;
      r.fail_count = fails;
      r.untracked_count = lost;
      r.requested_bytes = req_total;
      pending.push_back(r);
    endfunction

    // Compare one accepted result against the oldest prediction.
    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  ath_event_if  events ();
  ath_result_if results ();
  ath_cfg_if    cfg ();

  tracker_scoreboard sb;
  int unsigned idle_cycles;
  bit no_idle;
  logic [31:0] pool [64];

  allocation_tracker_hash_table_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .events  (events.sink),
    .results (results.source),
    .cfg     (cfg.sink)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    rst = 1'b1;
    events.valid = 1'b0;
    events.data = '0;
    results.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = '0;
  end

  function bit idle_roll();
    return !no_idle && ($urandom_range(99) < 31);
  endfunction

  // Drain results with random back-pressure, checking each transaction.
  always @(posedge clk) begin
    if (!rst) begin
      if (results.valid && results.ready) sb.check_result(results.data);
      results.ready <= !idle_roll();
    end
  end

  // Watchdog: count cycles with no transaction on any channel.
  always @(posedge clk) begin
    if (rst || (events.valid && events.ready) || (results.valid && results.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchdogLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Send one event; hold valid until the transaction completes and leave it
  // up so the next event can follow without a gap.
  task automatic send_event(logic [1:0] k, logic [31:0] a, logic [31:0] na,
                            logic [31:0] sz);
    event_t ev;
    ev.kind = k; ev.address = a; ev.new_address = na; ev.byte_count = sz;
    while (idle_roll()) begin
      events.valid <= 1'b0;
      @(posedge clk);
    end
    events.valid <= 1'b1;
    events.data <= ev;
    @(posedge clk);
    while (!events.ready) @(posedge clk);
    sb.note_event(ev);
  endtask

  // Drop valid, wait for every outstanding result, then let the block settle.
  task automatic drain();
    events.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  task automatic write_limit(logic [LimitBits-1:0] v);
    cfg.valid <= 1'b1;
    cfg.data <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    sb.limit = v;
    cfg.valid <= 1'b0;
  endtask

  // Mostly alloc/free/realloc on a small address pool so entries collide.
  task automatic random_phase(int n);
    logic [31:0] a, na, sz;
    logic [1:0] k;
    for (int i = 0; i < n; i++) begin
      no_idle = (i >= n / 3) && (i < n / 2);
      a = pool[$urandom_range(63)];
      na = pool[$urandom_range(63)];
      sz = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(4096);
      case ($urandom_range(19))
        0: a = 32'd0;
        1: a = $urandom();
        2: na = 32'd0;
        3: a = 32'd1;
        default: ;
      endcase
      k = ($urandom_range(39) == 0) ? KindNone : 2'($urandom_range(2));
      send_event(k, a, na, sz);
    end
    no_idle = 0;
  endtask

  initial begin
    sb = new();
    sb.clear();
    no_idle = 0;
    // Colliding addresses: home slots 4 to 7 only, plus random ones.
    for (int i = 0; i < 64; i++) begin
      if (i < 24) pool[i] = 32'h0010_0000 + (i << 18) + 32'h40;
      else pool[i] = $urandom() | 32'h2;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every kind, reserved address, kind 3.
    send_event(KindAlloc, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
    send_event(KindAlloc, 32'hFFFF_FFFF, 0, 32'd5);
    send_event(KindAlloc, 32'd0, 0, 32'd7);
    send_event(KindAlloc, 32'd1, 0, 32'd9);
    send_event(KindFree, 32'd1, 0, 0);
    send_event(KindAlloc, pool[0], 0, 32'd0);
    send_event(KindRealloc, pool[0], 0, 32'd3);
    send_event(KindAlloc, pool[1], 0, 32'd100);
    send_event(KindRealloc, pool[1], 0, 32'd0);
    send_event(KindRealloc, pool[1], pool[2], 32'd50);
    send_event(KindRealloc, 32'd0, pool[3], 32'd60);
    send_event(KindNone, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555);
    send_event(KindFree, pool[2], 0, 0);
    send_event(KindFree, pool[2], 0, 0);
    send_event(KindFree, 32'hFFFF_FFFF, 0, 0);
    send_event(KindFree, 32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    write_limit(9'd0);
    send_event(KindAlloc, pool[4], 0, 32'd10);
    send_event(KindFree, pool[3], 0, 0);
    drain();
    write_limit(9'd1);
    random_phase(300);
    drain();
    write_limit(9'd511);
    random_phase(500);
    drain();
    write_limit(9'd3);
    random_phase(400);
    drain();
    write_limit(9'd256);
    random_phase(600);
    drain();

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
